// ----- rtl/core/jrcm_pkg.sv -----
// Package of the joint residual collision monitor.
// Holds the item types, the register codes, the controller interface types and the
// saturation helper. It depends on nothing else.
package jrcm_pkg;

  // Largest number of joints one item carries.
  localparam int MAX_JOINTS = 4;

  // Register reset values.
  localparam logic [14:0] HPF_GAIN_RST      = 15'd7914;
  localparam logic [22:0] THRESH_OFFSET_RST = 23'd65536;
  localparam logic [3:0]  JOINT_ENABLE_RST  = 4'd7;

  // Envelope start values, minus and plus 10000 in Q16.16.
  localparam logic signed [31:0] ENV_INIT_HIGH = -32'sd655360000;
  localparam logic signed [31:0] ENV_INIT_LOW  = 32'sd655360000;

  // Rounding constant for a product with the Q1.15 gain.
  localparam logic signed [48:0] ROUND_Q15 = 49'sd16384;

  // Collision source codes.
  localparam logic [2:0] SRC_NONE = 3'd0;
  localparam logic [2:0] SRC_STOP = 3'd5;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 23;
  localparam logic [CFG_IDX_W-1:0] CFG_HPF_GAIN      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_THRESH_OFFSET = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_JOINT_ENABLE  = 2'd2;

  // Default joint count of the top level.
  localparam int JOINTS_DEF = 4;

  // One input item.
  typedef struct packed {
    logic signed [31:0] residual_j1;
    logic signed [31:0] residual_j2;
    logic signed [31:0] residual_j3;
    logic signed [31:0] residual_j4;
    logic               armed;
    logic               stop_request;
    logic               restart;
  } in_item_t;

  // One result item.
  typedef struct packed {
    logic signed [31:0] filtered_j1;
    logic signed [31:0] filtered_j2;
    logic signed [31:0] filtered_j3;
    logic signed [31:0] filtered_j4;
    logic               collision_flag;
    logic [2:0]         collision_source;
  } out_item_t;

  // Controller states.
  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_MUL1 = 6'b000010,
    ST_SUB  = 6'b000100,
    ST_MUL2 = 6'b001000,
    ST_FIN  = 6'b010000,
    ST_DONE = 6'b100000
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic start;
    logic mul1;
    logic sub;
    logic mul2;
    logic fin;
    logic load_out;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic last_joint;
    logic out_free;
  } status_t;

  // Saturate a wide signed value to the signed 32-bit range.
  function automatic logic signed [31:0] sat32(input logic signed [49:0] v);
    logic signed [31:0] r;
    if (v > 50'sd2147483647) begin
      r = 32'sh7FFFFFFF;
    end else if (v < -50'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

// ----- rtl/core/joint_residual_collision_monitor_unit.sv -----
// Top level of the joint residual collision monitor.
// Joins jrcm_ctrl and jrcm_dp; depends on jrcm_pkg.
//
// Usage:
//   The in channel (in_valid_i, in_ready_o, in_item_i) takes one item per servo tick
//   with up to four joint residuals and the armed, stop and restart levels. The out
//   channel (out_valid_o, out_ready_i, out_item_o) returns one item per input item
//   with the high-pass outputs and the latched collision flag and source.
//   The cfg channel (cfg_valid_i, cfg_ready_o, cfg_index_i, cfg_data_i) writes the
//   filter gain, the envelope margin and the joint enable mask; it is always ready
//   and is meant to be written while no item is in flight.
//   Sequence: an item is accepted in the idle state, then each joint passes through
//   the MUL1, SUB, MUL2 and FIN states around the single shared gain multiplier (two
//   products, one add, one update). After the last joint the result is loaded into the
//   output register; the next item is accepted only once the controller is back in idle.
//   The result sits in an output register, so the next item is accepted and worked
//   on while the receiver stalls; only the hand-off of a second result waits.
//   Reset clears the registers to their defaults, the filter history and warm-up
//   count to zero, the collision latch, and the envelopes to minus and plus 10000.
module joint_residual_collision_monitor_unit #(
  parameter int JOINTS = jrcm_pkg::JOINTS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  jrcm_pkg::in_item_t              in_item_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output jrcm_pkg::out_item_t             out_item_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [jrcm_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [jrcm_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  jrcm_pkg::cmd_t    cmd;
  jrcm_pkg::status_t status;

  assign cfg_ready_o = 1'b1;

  // Sequencer.
  jrcm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // Filter, envelope and output datapath.
  jrcm_dp #(
    .JOINTS (JOINTS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_item_i   (in_item_i),
    .cfg_we_i    (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

endmodule

// ----- rtl/core/jrcm_ctrl.sv -----
// Controller of the joint residual collision monitor.
// Sequences the four filter steps of every joint and the result hand-off.
// Depends on jrcm_pkg.
module jrcm_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  jrcm_pkg::status_t status_i,
  output jrcm_pkg::cmd_t    cmd_o
);

  jrcm_pkg::state_e state_q, state_d;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= jrcm_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o = (state_q == jrcm_pkg::ST_IDLE);

  // Next state and commands.
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      jrcm_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.start = 1'b1;
          state_d     = jrcm_pkg::ST_MUL1;
        end
      end
      jrcm_pkg::ST_MUL1: begin
        cmd_o.mul1 = 1'b1;
        state_d    = jrcm_pkg::ST_SUB;
      end
      jrcm_pkg::ST_SUB: begin
        cmd_o.sub = 1'b1;
        state_d   = jrcm_pkg::ST_MUL2;
      end
      jrcm_pkg::ST_MUL2: begin
        cmd_o.mul2 = 1'b1;
        state_d    = jrcm_pkg::ST_FIN;
      end
      jrcm_pkg::ST_FIN: begin
        cmd_o.fin = 1'b1;
        state_d   = status_i.last_joint ? jrcm_pkg::ST_DONE : jrcm_pkg::ST_MUL1;
      end
      jrcm_pkg::ST_DONE: begin
        if (status_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = jrcm_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = jrcm_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// ----- rtl/core/jrcm_dp.sv -----
// Datapath of the joint residual collision monitor.
// Holds the registers, filter history, envelopes, the shared gain multiplier and
// the output register. Depends on jrcm_pkg.
module jrcm_dp #(
  parameter int JOINTS = jrcm_pkg::JOINTS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  jrcm_pkg::in_item_t                  in_item_i,
  input  logic                                cfg_we_i,
  input  logic [jrcm_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [jrcm_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  jrcm_pkg::cmd_t                      cmd_i,
  output jrcm_pkg::status_t                   status_o,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output jrcm_pkg::out_item_t                 out_item_o
);

  localparam int JW = (JOINTS > 1) ? $clog2(JOINTS) : 1;

  // Configuration registers.
  logic [14:0] hpf_gain_q;
  logic [22:0] thresh_offset_q;
  logic [3:0]  joint_enable_q;

  // Item state.
  jrcm_pkg::in_item_t in_q;
  logic [JW-1:0]      jidx_q;
  logic               active_q;
  logic [1:0]         warm_q;
  logic               armed_before_q;
  logic               latch_q;
  logic [2:0]         src_q;
  logic [2:0]         hit_q;

  logic signed [31:0] hist_q  [JOINTS];
  logic signed [31:0] env_hi_q[JOINTS];
  logic signed [31:0] env_lo_q[JOINTS];
  logic signed [31:0] y_q     [JOINTS];

  // Shared multiplier path.
  logic signed [48:0] prod_q;
  logic signed [31:0] z_q;
  logic signed [32:0] d_q;

  logic               out_valid_q;
  jrcm_pkg::out_item_t out_q;

  logic signed [31:0] x_arr[jrcm_pkg::MAX_JOINTS];
  logic signed [31:0] x_cur;
  logic signed [31:0] zp_cur;
  logic signed [15:0] k_s;
  logic signed [32:0] mul_b;
  logic signed [48:0] mul_p;
  logic signed [48:0] rnd;
  logic signed [31:0] z_new;
  logic signed [31:0] y_filt;
  logic signed [31:0] y_new;
  logic               restart_act;
  logic               active_new;
  logic               out_of_env;
  logic               check_now;
  logic [2:0]         src_new;
  logic               latch_new;
  logic [2:0]         src_fin;

  // Residual selection for the current joint.
  assign x_arr[0] = in_q.residual_j1;
  assign x_arr[1] = in_q.residual_j2;
  assign x_arr[2] = in_q.residual_j3;
  assign x_arr[3] = in_q.residual_j4;
  assign x_cur    = x_arr[jidx_q];
  assign zp_cur   = hist_q[jidx_q];

  // One multiplier serves both gain products.
  assign k_s   = {1'b0, hpf_gain_q};
  assign mul_b = cmd_i.mul2 ? d_q : {zp_cur[31], zp_cur};
  assign mul_p = k_s * mul_b;
  assign rnd   = (prod_q + jrcm_pkg::ROUND_Q15) >>> 15;

  // New history value and filtered output.
  assign z_new  = jrcm_pkg::sat32(50'(x_cur) + 50'(rnd));
  assign y_filt = jrcm_pkg::sat32(50'(rnd));
  assign y_new  = active_q ? y_filt : x_cur;

  // Warm-up state at the start of an item.
  assign restart_act = in_item_i.restart;
  assign active_new  = !restart_act && (warm_q == 2'd2);

  // Envelope check of the current joint.
  assign out_of_env = (y_new > env_hi_q[jidx_q]) || (y_new < env_lo_q[jidx_q]);
  assign check_now  = active_q && in_q.armed && !latch_q && joint_enable_q[jidx_q];

  // Collision decision at the end of an item.
  always_comb begin
    src_fin = src_q;
    latch_new = latch_q;
    if (hit_q != jrcm_pkg::SRC_NONE) begin
      src_new = hit_q;
    end else if (in_q.stop_request) begin
      src_new = jrcm_pkg::SRC_STOP;
    end else begin
      src_new = jrcm_pkg::SRC_NONE;
    end
    if (active_q && in_q.armed && !latch_q && (src_new != jrcm_pkg::SRC_NONE)) begin
      latch_new = 1'b1;
      src_fin   = src_new;
    end
  end

  assign status_o.last_joint = (jidx_q == JW'(JOINTS - 1));
  assign status_o.out_free   = !out_valid_q || out_ready_i;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hpf_gain_q      <= jrcm_pkg::HPF_GAIN_RST;
      thresh_offset_q <= jrcm_pkg::THRESH_OFFSET_RST;
      joint_enable_q  <= jrcm_pkg::JOINT_ENABLE_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        jrcm_pkg::CFG_HPF_GAIN:      hpf_gain_q      <= cfg_data_i[14:0];
        jrcm_pkg::CFG_THRESH_OFFSET: thresh_offset_q <= cfg_data_i[22:0];
        jrcm_pkg::CFG_JOINT_ENABLE:  joint_enable_q  <= cfg_data_i[3:0];
        default: begin
        end
      endcase
    end
  end

  // Control state of the item in flight.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      jidx_q         <= '0;
      active_q       <= 1'b0;
      warm_q         <= 2'd0;
      armed_before_q <= 1'b0;
      latch_q        <= 1'b0;
      src_q          <= jrcm_pkg::SRC_NONE;
      hit_q          <= jrcm_pkg::SRC_NONE;
      out_valid_q    <= 1'b0;
    end else begin
      if (cmd_i.start) begin
        jidx_q         <= '0;
        hit_q          <= jrcm_pkg::SRC_NONE;
        active_q       <= active_new;
        armed_before_q <= in_item_i.armed;
        if (restart_act) begin
          warm_q  <= 2'd1;
          latch_q <= 1'b0;
          src_q   <= jrcm_pkg::SRC_NONE;
        end else if (warm_q != 2'd2) begin
          warm_q <= warm_q + 2'd1;
        end
      end
      if (cmd_i.fin) begin
        jidx_q <= jidx_q + JW'(1);
        if (check_now && out_of_env) begin
          hit_q <= 3'(jidx_q) + 3'd1;
        end
      end
      if (cmd_i.load_out) begin
        latch_q     <= latch_new;
        src_q       <= src_fin;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Filter history and envelopes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < JOINTS; i++) begin
        hist_q[i]   <= '0;
        env_hi_q[i] <= jrcm_pkg::ENV_INIT_HIGH;
        env_lo_q[i] <= jrcm_pkg::ENV_INIT_LOW;
      end
    end else begin
      if (cmd_i.start) begin
        for (int i = 0; i < JOINTS; i++) begin
          if (restart_act) begin
            hist_q[i] <= '0;
          end
          if (in_item_i.armed && !armed_before_q) begin
            env_hi_q[i] <= jrcm_pkg::sat32(50'(env_hi_q[i]) + 50'(thresh_offset_q));
            env_lo_q[i] <= jrcm_pkg::sat32(50'(env_lo_q[i]) - 50'(thresh_offset_q));
          end else if (!in_item_i.armed && armed_before_q) begin
            env_hi_q[i] <= jrcm_pkg::ENV_INIT_HIGH;
            env_lo_q[i] <= jrcm_pkg::ENV_INIT_LOW;
          end
        end
      end
      if (cmd_i.fin) begin
        hist_q[jidx_q] <= active_q ? z_q : x_cur;
        // Learn the envelope while unarmed.
        if (active_q && !in_q.armed) begin
          if (y_new > env_hi_q[jidx_q]) begin
            env_hi_q[jidx_q] <= y_new;
          end
          if (y_new < env_lo_q[jidx_q]) begin
            env_lo_q[jidx_q] <= y_new;
          end
        end
      end
    end
  end

  // Payload registers of the working path.
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      in_q <= in_item_i;
    end
    if (cmd_i.mul1 || cmd_i.mul2) begin
      prod_q <= mul_p;
    end
    if (cmd_i.sub) begin
      z_q <= z_new;
      d_q <= 33'(z_new) - 33'(zp_cur);
    end
    if (cmd_i.fin) begin
      y_q[jidx_q] <= y_new;
    end
  end

  // Output register; joints beyond the joint count read zero.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_q.filtered_j1      <= y_q[0];
      out_q.filtered_j2      <= '0;
      out_q.filtered_j3      <= '0;
      out_q.filtered_j4      <= '0;
      out_q.collision_flag   <= latch_new;
      out_q.collision_source <= src_fin;
      for (int i = 1; i < JOINTS; i++) begin
        unique case (i)
          1: out_q.filtered_j2 <= y_q[i];
          2: out_q.filtered_j3 <= y_q[i];
          default: out_q.filtered_j4 <= y_q[i];
        endcase
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule
